[design/edge_shell_orderer_unit_assert.svh]
// Assertion macros used by the RTL.
`ifndef EDGE_SHELL_ORDERER_UNIT_ASSERT_SVH
`define EDGE_SHELL_ORDERER_UNIT_ASSERT_SVH
// Antecedent implies consequent on the next cycle.
`define ESO_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ESO_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`endif

[design/eso_pkg.sv]
`default_nettype none
package eso_pkg;
  localparam int MaxShellDef   = 32;
  localparam int VertexBitsDef = 24;
  localparam int IdBits        = 24;
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadFirst = 2'd1;
  localparam logic [1:0] StatusStuck    = 2'd2;

  // Parity of the corner permutation: 1 same, 0 opposite; ok=0 when no match.
  function automatic logic [1:0] orient_f(input logic [31:0] r0, input logic [31:0] r1,
                                          input logic [31:0] r2, input logic [31:0] r3,
                                          input logic [31:0] t0, input logic [31:0] t1,
                                          input logic [31:0] t2, input logic [31:0] t3);
    logic [31:0] rf [4];
    logic [31:0] tt [4];
    logic [2:0] pc [4];
    logic [2:0] b;
    logic [2:0] pos;
    logic fnd, ok, dn;
    logic [2:0] sw;
    rf[0] = r0; rf[1] = r1; rf[2] = r2; rf[3] = r3;
    tt[0] = t0; tt[1] = t1; tt[2] = t2; tt[3] = t3;
    for (int i = 0; i < 4; i++) pc[i] = 3'd4;
    ok = 1'b1;
    sw = '0;
    for (int i = 0; i < 4; i++) begin
      fnd = 1'b0;
      pos = '0;
      for (int k = 0; k < 4; k++)
        if (rf[k] == tt[i]) begin
          fnd = 1'b1;
          pos = 3'(k);
        end
      if (!fnd) ok = 1'b0;
      else pc[pos[1:0]] = 3'(i);
    end
    for (int i = 0; i < 4; i++) begin
      if (pc[i] != 3'(i)) begin
        dn = 1'b0;
        for (int j = 0; j < 4; j++)
          if (j >= i && !dn && pc[j] == 3'(i)) begin
            b = pc[i];
            pc[i] = pc[j];
            pc[j] = b;
            sw = sw + 3'd1;
            dn = 1'b1;
          end
      end
    end
    return {ok, ~sw[0]};
  endfunction
endpackage
`default_nettype wire

[design/eso_if.sv]
`default_nettype none
interface eso_in_if import eso_pkg::*; #(parameter int VertexBits = VertexBitsDef);
  logic valid, ready;
  logic [IdBits-1:0] tetra_id;
  logic [VertexBits-1:0] corner_zero, corner_one, corner_two, corner_three;
  logic [VertexBits-1:0] edge_start, edge_end;
  logic shell_last;
  modport source(output valid, tetra_id, corner_zero, corner_one, corner_two, corner_three,
                 edge_start, edge_end, shell_last, input ready);
  modport sink(input valid, tetra_id, corner_zero, corner_one, corner_two, corner_three,
               edge_start, edge_end, shell_last, output ready);
endinterface

interface eso_out_if import eso_pkg::*;;
  logic valid, ready;
  logic [IdBits-1:0] ordered_id;
  logic run_last, on_border;
  logic [1:0] status;
  modport source(output valid, ordered_id, run_last, on_border, status, input ready);
  modport sink(input valid, ordered_id, run_last, on_border, status, output ready);
endinterface
`default_nettype wire

[design/edge_shell_orderer_unit.sv]
// Edge shell orderer.
// Load: one beat per cycle while in the load state, no result unless shell_last.
// Ordering: seed from tetrahedron 0 (S_FIRST read, then the seed test), then each
// candidate takes a memory read (S_RD) then a link test (S_TEST).
// Emit: order read (S_ERD), then id read with valid in S_EOUT; the next beat starts after the last is taken.
// Synchronous reset clears control state only; the stores are undefined until loaded.
`default_nettype none
`include "edge_shell_orderer_unit_assert.svh"
module edge_shell_orderer_unit import eso_pkg::*; #(
  parameter int MaxShell   = MaxShellDef,
  parameter int VertexBits = VertexBitsDef
) (
  input  wire logic clk,
  input  wire logic rst,
  eso_in_if.sink    in_ch,
  eso_out_if.source out_ch
);
  localparam int IW = (MaxShell > 1) ? $clog2(MaxShell) : 1;
  localparam int CW = $clog2(MaxShell + 1);
  localparam int LW = $clog2(2 * MaxShell + 1);
  localparam int OW = (MaxShell > 0) ? $clog2(2 * MaxShell) : 1;
  localparam int RW = 4 * VertexBits + 2 * VertexBits + 1;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_ERD   = 3'd4;
  localparam logic [2:0] S_EOUT  = 3'd5;

  typedef logic [VertexBits-1:0] vtx_t;

  // Shell memory: corners, opposite pair, opposite count flag
  logic [RW-1:0] shell_mem [MaxShell];
  logic [IdBits-1:0] id_mem [MaxShell];
  logic [IW-1:0] order_mem [2*MaxShell];
  logic [RW-1:0] rd_row;
  logic [IdBits-1:0] rd_id;
  logic [IW-1:0] rd_ord;

  logic [2:0] state;
  logic [CW-1:0] count, n;
  vtx_t e0, e1, front, back;
  logic [LW-1:0] head, tail;
  logic [IW-1:0] cand, rd_addr;
  logic [OW-1:0] ord_addr;
  logic [LW-1:0] ord_wr;
  logic dir_back, reverse, found_any;
  logic [1:0] stat;
  logic [CW-1:0] placed;
  logic [LW-1:0] emit_ptr;

  // Opposite pair on load
  vtx_t ce0, ce1, c [4];
  vtx_t op0, op1;
  logic [1:0] oc;
  always_comb begin
    ce0 = (count == '0) ? in_ch.edge_start : e0;
    ce1 = (count == '0) ? in_ch.edge_end : e1;
    c[0] = in_ch.corner_zero; c[1] = in_ch.corner_one;
    c[2] = in_ch.corner_two;  c[3] = in_ch.corner_three;
    op0 = '0; op1 = '0; oc = '0;
    for (int k = 0; k < 4; k++)
      if (oc < 2'd2 && c[k] != ce0 && c[k] != ce1) begin
        if (oc == 2'd0) op0 = c[k];
        else op1 = c[k];
        oc = oc + 2'd1;
      end
  end

  assign in_ch.ready = (state == S_LOAD);
  wire load_fire = in_ch.valid && in_ch.ready;
  wire store_ok = (count < CW'(MaxShell));

  // Row fields
  vtx_t r0, r1, r2, r3, ro0, ro1;
  logic r_two;
  assign {r_two, ro1, ro0, r3, r2, r1, r0} = rd_row;

  // Link test against the walk vertex
  vtx_t v, other, t2a, t3a, t2b, t3b;
  logic [1:0] g0, g1, gf;
  logic hit0, hit1;
  always_comb begin
    v = dir_back ? front : back;
    t2a = dir_back ? ro1 : v;  t3a = dir_back ? v : ro1;
    t2b = dir_back ? ro0 : v;  t3b = dir_back ? v : ro0;
    g0 = orient_f(32'(r0), 32'(r1), 32'(r2), 32'(r3), 32'(e0), 32'(e1), 32'(t2a), 32'(t3a));
    g1 = orient_f(32'(r0), 32'(r1), 32'(r2), 32'(r3), 32'(e0), 32'(e1), 32'(t2b), 32'(t3b));
    gf = orient_f(32'(r0), 32'(r1), 32'(r2), 32'(r3), 32'(e0), 32'(e1), 32'(ro0), 32'(ro1));
    hit0 = r_two && ro0 == v && g0 == 2'b11;
    hit1 = r_two && ro1 == v && g1 == 2'b11;
    other = hit0 ? ro1 : ro0;
  end

  // Order list slot: seed and forward links at tail, backward links just before head
  assign ord_wr = dir_back ? head - LW'(1) : tail;

  // Memory writes and registered reads
  always_ff @(posedge clk) begin
    if (load_fire && store_ok) begin
      shell_mem[count[IW-1:0]] <= {oc == 2'd2, op1, op0, c[3], c[2], c[1], c[0]};
      id_mem[count[IW-1:0]] <= in_ch.tetra_id;
    end
    if (state == S_TEST && (!found_any || hit0 || hit1))
      order_mem[ord_wr[OW-1:0]] <= cand;
    rd_row <= shell_mem[rd_addr];
    rd_ord <= order_mem[ord_addr];
    rd_id  <= id_mem[rd_ord];
  end

  always_comb begin
    rd_addr = cand;
    if (state == S_LOAD) rd_addr = '0;
    ord_addr = emit_ptr[OW-1:0];
  end

  wire cand_end = (CW'(cand) + CW'(1) >= n);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      e0 <= '0; e1 <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (load_fire) begin
            if (count == '0) begin
              e0 <= in_ch.edge_start;
              e1 <= in_ch.edge_end;
            end
            if (in_ch.shell_last) begin
              n <= store_ok ? count + CW'(1) : count;
              count <= '0;
              if (store_ok || count != '0) state <= S_FIRST;
            end else if (store_ok) begin
              count <= count + CW'(1);
            end
            cand <= '0;
          end
        end
        S_FIRST: begin
          // tetrahedron 0 is read at this edge, the seed test follows
          state <= S_TEST;
          dir_back <= 1'b0;
          reverse <= 1'b0;
          stat <= StatusOk;
          placed <= CW'(1);
          head <= LW'(MaxShell);
          tail <= LW'(MaxShell);
          cand <= IW'(0);
          found_any <= 1'b0;
        end
        S_RD: state <= S_TEST;
        S_TEST: begin
          if (!found_any) begin
            // seed from tetrahedron 0
            if (r_two && gf == 2'b11) begin front <= ro0; back <= ro1; end
            else if (r_two && gf == 2'b10) begin front <= ro1; back <= ro0; end
            else begin front <= '0; back <= '0; stat <= StatusBadFirst; end
            tail <= LW'(MaxShell) + LW'(1);
            found_any <= 1'b1;
            if (n == CW'(1)) begin
              state <= S_ERD; emit_ptr <= LW'(MaxShell);
            end else begin
              cand <= IW'(1); state <= S_RD;
            end
          end else if (hit0 || hit1) begin
            if (dir_back) begin front <= other; head <= head - LW'(1); end
            else begin back <= other; tail <= tail + LW'(1); end
            placed <= placed + CW'(1);
            if (placed + CW'(1) == n) begin
              state <= S_ERD;
              emit_ptr <= dir_back ? head - LW'(1) : LW'(MaxShell);
            end else begin
              cand <= dir_back ? '0 : IW'(1);
              state <= S_RD;
            end
          end else if (!cand_end) begin
            cand <= cand + IW'(1);
            state <= S_RD;
          end else if (!dir_back) begin
            dir_back <= 1'b1; reverse <= 1'b1;
            cand <= '0; state <= S_RD;
          end else begin
            if (stat == StatusOk) stat <= StatusStuck;
            emit_ptr <= head;
            state <= S_ERD;
          end
        end
        S_ERD: begin
          // order read, then id read
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_EOUT;
          end
        end
        S_EOUT: begin
          state <= S_EOUT;
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.run_last <= (emit_ptr + LW'(1) == tail);
            out_ch.on_border <= reverse;
            out_ch.status <= stat;
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.run_last) state <= S_LOAD;
            else begin emit_ptr <= emit_ptr + LW'(1); state <= S_ERD; end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign out_ch.ordered_id = rd_id;

  `ESO_ASSERT_SAME(a_ready_load, clk, rst, in_ch.ready, state == S_LOAD)
  `ESO_ASSERT_SAME(a_no_out_load, clk, rst, state == S_LOAD, !out_ch.valid)
  `ESO_ASSERT_NEXT(a_last_ret, clk, rst,
    out_ch.valid && out_ch.ready && out_ch.run_last, state == S_LOAD)
endmodule
`default_nettype wire

[tb/sv/tb_edge_shell_orderer_unit.sv]
`default_nettype none
module tb_edge_shell_orderer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import eso_pkg::*;

  localparam int ShellCap   = MaxShellDef;
  localparam int CycleLimit = 2000000;
  localparam int LongHold   = 3000;

  typedef logic [VertexBitsDef-1:0] vtx_t;

  typedef struct packed {
    logic [IdBits-1:0] id;
    vtx_t c0, c1, c2, c3, es, ee;
    logic last;
  } tet_beat_t;

  typedef struct packed {
    logic [IdBits-1:0] id;
    logic run_last;
    logic on_border;
    logic [1:0] status;
  } order_beat_t;

  // Shell ordering predictor and queue of pending ordered ids
  class shell_scoreboard;
    order_beat_t pending[$];
    int errors;
    int fill;
    vtx_t ends[2];
    logic [IdBits-1:0] ids[ShellCap];
    vtx_t corners[ShellCap][4];
    vtx_t opp[ShellCap][2];
    int opp_n[ShellCap];

    function new();
      errors = 0;
      fill = 0;
      ends[0] = '0;
      ends[1] = '0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // 1 same orientation, 0 opposite, -1 corner sets differ
    function int orient(vtx_t r[4], vtx_t t[4]);
      int pc[4];
      int pos, swaps, b;
      swaps = 0;
      for (int i = 0; i < 4; i++) pc[i] = 4;
      for (int i = 0; i < 4; i++) begin
        pos = -1;
        for (int k = 0; k < 4; k++) if (r[k] == t[i]) pos = k;
        if (pos < 0) return -1;
        pc[pos] = i;
      end
      for (int i = 0; i < 4; i++) begin
        if (pc[i] != i) begin
          for (int j = i; j < 4; j++) begin
            if (pc[j] == i) begin
              b = pc[i];
              pc[i] = pc[j];
              pc[j] = b;
              swaps++;
              break;
            end
          end
        end
      end
      return (swaps % 2 == 0) ? 1 : 0;
    endfunction

    function bit link(int j, vtx_t v, bit backward, output vtx_t nv);
      vtx_t t[4];
      vtx_t other;
      nv = '0;
      if (opp_n[j] < 2) return 0;
      for (int s = 0; s < 2; s++) begin
        other = opp[j][1-s];
        if (opp[j][s] != v) continue;
        t[0] = ends[0];
        t[1] = ends[1];
        t[2] = backward ? other : v;
        t[3] = backward ? v : other;
        if (orient(corners[j], t) == 1) begin
          nv = other;
          return 1;
        end
      end
      return 0;
    endfunction

    function void note_tetra(tet_beat_t b);
      int n, fwd_n, back_n, total, g, c, idx;
      int chain[ShellCap];
      int back[ShellCap];
      vtx_t head, tail, nv, v;
      vtx_t t[4];
      vtx_t cin[4];
      logic [1:0] st;
      bit reversed, stuck, found;
      order_beat_t r;
      if (fill == 0) begin
        ends[0] = b.es;
        ends[1] = b.ee;
      end
      // load, dropping beats past the shell capacity
      if (fill < ShellCap) begin
        cin[0] = b.c0; cin[1] = b.c1; cin[2] = b.c2; cin[3] = b.c3;
        c = 0;
        ids[fill] = b.id;
        for (int k = 0; k < 4; k++) begin
          v = cin[k];
          corners[fill][k] = v;
          if (c < 2 && v != ends[0] && v != ends[1]) begin
            opp[fill][c] = v;
            c++;
          end
        end
        for (int k = c; k < 2; k++) opp[fill][k] = '0;
        opp_n[fill] = c;
        fill++;
      end
      if (!b.last) return;
      n = fill;
      fill = 0;
      st = StatusOk;
      reversed = 0;
      stuck = 0;
      head = '0;
      tail = '0;
      // start direction from the first tetrahedron
      g = -1;
      if (opp_n[0] == 2) begin
        t[0] = ends[0]; t[1] = ends[1]; t[2] = opp[0][0]; t[3] = opp[0][1];
        g = orient(corners[0], t);
      end
      if (g == 1) begin
        head = opp[0][0]; tail = opp[0][1];
      end else if (g == 0) begin
        head = opp[0][1]; tail = opp[0][0];
      end else st = StatusBadFirst;
      // forward walk
      chain[0] = 0;
      fwd_n = 1;
      for (int i = 1; i < n; i++) begin
        found = 0;
        for (int j = 1; j < n; j++) begin
          if (link(j, tail, 0, nv)) begin
            chain[fwd_n++] = j;
            tail = nv;
            found = 1;
            break;
          end
        end
        if (!found) begin
          reversed = 1;
          break;
        end
      end
      // backward walk from the first vertex after a border
      back_n = 0;
      if (reversed) begin
        for (int i = fwd_n; i < n; i++) begin
          found = 0;
          for (int j = 0; j < n; j++) begin
            if (link(j, head, 1, nv)) begin
              back[back_n++] = j;
              head = nv;
              found = 1;
              break;
            end
          end
          if (!found) begin
            stuck = 1;
            break;
          end
        end
      end
      if (stuck && st == StatusOk) st = StatusStuck;
      total = back_n + fwd_n;
      for (int k = 0; k < total; k++) begin
        idx = (k < back_n) ? back[back_n-1-k] : chain[k-back_n];
        r.id = ids[idx];
        r.run_last = (k + 1 == total);
        r.on_border = reversed;
        r.status = st;
        pending = {pending, r};
      end
    endfunction

    task check_order(order_beat_t got);
      order_beat_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", got, 0);
        return;
      end
      want = pending.pop_front();
      if (got.id !== want.id) report("ordered_id", got.id, want.id);
      if (got.run_last !== want.run_last) report("run_last", got.run_last, want.run_last);
      if (got.on_border !== want.on_border) report("on_border", got.on_border, want.on_border);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic clk, rst;
  eso_in_if in_ch();
  eso_out_if out_ch();

  edge_shell_orderer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  shell_scoreboard sb;
  int cycles;
  bit quiet;
  bit hold_req;
  int hold_left;
  int ready_gap;
  int sent;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.tetra_id = '0;
    in_ch.corner_zero = '0;
    in_ch.corner_one = '0;
    in_ch.corner_two = '0;
    in_ch.corner_three = '0;
    in_ch.edge_start = '0;
    in_ch.edge_end = '0;
    in_ch.shell_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted beats, random stalls, long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      ready_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_order({out_ch.ordered_id, out_ch.run_last, out_ch.on_border, out_ch.status});
      if (hold_req) begin
        hold_req = 0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // drive one tetrahedron beat and wait for acceptance
  task automatic send_tetra(tet_beat_t b);
    in_ch.valid <= 1'b1;
    in_ch.tetra_id <= b.id;
    in_ch.corner_zero <= b.c0;
    in_ch.corner_one <= b.c1;
    in_ch.corner_two <= b.c2;
    in_ch.corner_three <= b.c3;
    in_ch.edge_start <= b.es;
    in_ch.edge_end <= b.ee;
    in_ch.shell_last <= b.last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tetra(b);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // corners a, b, p, q in a random order of the requested parity
  function automatic tet_beat_t make_tetra(logic [IdBits-1:0] id, vtx_t a, vtx_t b,
                                           vtx_t p, vtx_t q, bit flip);
    tet_beat_t t;
    vtx_t v[4];
    int perm[4];
    int inv, x, tmp;
    v[0] = a; v[1] = b; v[2] = p; v[3] = q;
    for (int i = 0; i < 4; i++) perm[i] = i;
    for (int i = 3; i > 0; i--) begin
      x = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[x]; perm[x] = tmp;
    end
    inv = 0;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++) if (perm[i] > perm[j]) inv++;
    if ((inv % 2 == 1) != flip) begin
      tmp = perm[0]; perm[0] = perm[1]; perm[1] = tmp;
    end
    t.id = id;
    t.c0 = v[perm[0]]; t.c1 = v[perm[1]]; t.c2 = v[perm[2]]; t.c3 = v[perm[3]];
    t.es = a;
    t.ee = b;
    t.last = 1'b0;
    return t;
  endfunction

  // one shell around edge (a, b); kind 0 ring, 1 open chain, 2 broken, 3 noise
  task automatic send_shell(int n, int kind, vtx_t a, vtx_t b);
    tet_beat_t beats[$];
    tet_beat_t t;
    vtx_t ring[$];
    int x;
    int span;
    span = (kind == 0) ? n : n + 1;
    for (int i = 0; i < span; i++) ring = {ring, vtx_t'($urandom)};
    for (int i = 0; i < n; i++) begin
      if (kind == 3 && $urandom_range(0, 1))
        t = make_tetra(IdBits'($urandom), vtx_t'($urandom), vtx_t'($urandom),
                       vtx_t'($urandom), vtx_t'($urandom), 0);
      else
        t = make_tetra(IdBits'($urandom), a, b, ring[i], ring[(i + 1) % span],
                       kind == 2 && $urandom_range(0, 3) == 0);
      beats = {beats, t};
    end
    // shuffle the load order
    for (int i = n - 1; i > 0; i--) begin
      x = $urandom_range(0, i);
      t = beats[i]; beats[i] = beats[x]; beats[x] = t;
    end
    for (int i = 0; i < n; i++) begin
      t = beats[i];
      if (i > 0 && $urandom_range(0, 1)) begin
        t.es = vtx_t'($urandom);
        t.ee = vtx_t'($urandom);
      end
      t.last = (i == n - 1);
      send_tetra(t);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * ShellCap * ShellCap + 200) @(posedge clk);
  endtask

  int sz, kind;
  tet_beat_t t;

  initial begin
    sb = new();
    cycles = 0;
    quiet = 0;
    hold_req = 0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single tetra, extremes of vertex values
    t = make_tetra(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'hFFFFFE, 0);
    t.last = 1'b1;
    send_tetra(t);
    // first tetrahedron without the edge
    t = make_tetra(24'h000000, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 0);
    t.es = 24'hAAAAAA; t.ee = 24'h555555;
    send_tetra(t);
    t = make_tetra(24'h000001, 24'hAAAAAA, 24'h555555, 24'h333333, 24'h444444, 0);
    t.last = 1'b1;
    send_tetra(t);
    // short opposite pair: repeated edge corners
    t.id = 24'h123456; t.c0 = 24'h7; t.c1 = 24'h7; t.c2 = 24'h9; t.c3 = 24'h8;
    t.es = 24'h7; t.ee = 24'h8; t.last = 1'b0;
    send_tetra(t);
    t.id = 24'h654321; t.c3 = 24'h5; t.last = 1'b1;
    send_tetra(t);
    // closed ring, open border, broken chain
    send_shell(5, 0, 24'h000000, 24'hFFFFFF);
    send_shell(4, 1, 24'hFFFFFF, 24'h000000);
    send_shell(5, 2, 24'h00F00F, 24'hF00F00);
    drain();

    // random shells, mostly well formed and small
    while (sent < 300) begin
      if ($urandom_range(0, 15) == 0) sz = $urandom_range(20, ShellCap + 3);
      else sz = $urandom_range(1, 8);
      kind = $urandom_range(0, 9);
      kind = (kind < 4) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
      if (sent > 80 && sent < 90) hold_req = 1;
      if (sent > 160 && sent < 170) drain();
      if (sent > 250) quiet = 1;
      send_shell(sz, kind, vtx_t'($urandom), vtx_t'($urandom));
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * ShellCap * ShellCap + 200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+design
design/eso_pkg.sv
design/eso_if.sv
design/edge_shell_orderer_unit.sv
tb/sv/tb_edge_shell_orderer_unit.sv
